// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chme: assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_AT(lbl, !(cond))

`endif

// ----- design/chme_pkg.sv -----
// ----------------------------------------------------------------------------
// chme_pkg
// Sizes, codes and shared structs of the chained hash map engine.
// ----------------------------------------------------------------------------
package chme_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int OP_W       = 2;
  localparam int STS_W      = 2;

  // Entry pool split over a row of cells, up to eight entries per cell
  localparam int CELL_SLOTS = (TABLE_SIZE < 8) ? TABLE_SIZE : 8;
  localparam int NUM_CELLS  = (TABLE_SIZE + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int SLOT_W     = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
  localparam int CELL_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // Stream word widths
  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STS_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_DONE
  } fsm_e;

  // Search token handed along the cell row
  typedef struct packed {
    logic              vld;
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              hit;
    logic [CELL_W-1:0] hit_cell;
    logic [SLOT_W-1:0] hit_slot;
    logic [VAL_W-1:0]  hit_value;
    logic              free;
    logic [CELL_W-1:0] free_cell;
    logic [SLOT_W-1:0] free_slot;
  } tok_t;

  // Store update broadcast to all cells
  typedef struct packed {
    logic              en;
    logic              kill;
    logic [CELL_W-1:0] cell_idx;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cmt_t;

endpackage

// ----- design/chme_cell.sv -----
// ----------------------------------------------------------------------------
// chme_cell
// One cell of the entry row: holds a few entries, checks the passing token.
// ----------------------------------------------------------------------------
module chme_cell import chme_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CELL_W-1:0]     cell_id_i,
  input  logic [CELL_SLOTS-1:0] slot_en_i,
  input  tok_t                  tok_i,
  output tok_t                  tok_o,
  input  cmt_t                  cmt_i
);

  logic [CELL_SLOTS-1:0] valid_q;
  logic [KEY_W-1:0]      key_q   [CELL_SLOTS];
  logic [VAL_W-1:0]      value_q [CELL_SLOTS];

  tok_t              tok_q, tok_d;
  logic              match, free;
  logic [SLOT_W-1:0] mslot, fslot;
  logic              sel;

  assign sel = cmt_i.en && (cmt_i.cell_idx == cell_id_i);

  // lowest matching and lowest free slot
  always_comb begin
    match = 1'b0;
    mslot = '0;
    free  = 1'b0;
    fslot = '0;
    for (int s = CELL_SLOTS - 1; s >= 0; s--) begin
      if (slot_en_i[s] && valid_q[s] && (key_q[s] == tok_i.key)) begin
        match = 1'b1;
        mslot = SLOT_W'(s);
      end
      if (slot_en_i[s] && !valid_q[s]) begin
        free  = 1'b1;
        fslot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_cell  = cell_id_i;
      tok_d.hit_slot  = mslot;
      tok_d.hit_value = value_q[mslot];
    end
    if (!tok_i.free && free) begin
      tok_d.free      = 1'b1;
      tok_d.free_cell = cell_id_i;
      tok_d.free_slot = fslot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (sel) begin
      valid_q[cmt_i.slot] <= !cmt_i.kill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && !cmt_i.kill) begin
      key_q[cmt_i.slot]   <= cmt_i.key;
      value_q[cmt_i.slot] <= cmt_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- design/chained_hash_map_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key/value map, 64-bit keys and values, insert/remove/get over a cell row.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata                            tuser
//  s_axis    in   key, value_in                    op
//  m_axis    out  value_out, live_entries, pad     status, found
//
//  Flow: one word at a time; the next word is accepted only once the last
//    one is through: the token is loaded, passes each cell of the row, the
//    tail is taken and then the result and the update settle.
//  Reset: valid marks and the live count clear at once, no clearing pass.
//  Stalls: a result waits in the output register; the next word is accepted
//    while it waits, and only the closing step of that word holds for it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chained_hash_map_engine import chme_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // key, value_in
  input  logic [OP_W-1:0]       s_axis_tuser_i,   // op
  // master side
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // value_out, live_entries, zero pad
  output logic [OUT_USER_W-1:0] m_axis_tuser_o    // status, found
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  fsm_e fsm_q, fsm_d;

  tok_t inj_q, inj_d;             // token entering the first cell
  tok_t tail_q;                   // token held after the last cell
  tok_t tok_w [NUM_CELLS+1];      // token chain between cells
  cmt_t cmt_q, cmt_d;             // update broadcast to the row
  logic [CNT_W-1:0] count_q, count_d;

  logic                  m_vld_q;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [OUT_USER_W-1:0] m_user_q, m_user_d;

  logic    s_acc;
  logic    out_free;
  logic    finish;
  logic    tail_vld;
  status_e status;
  logic    found;
  logic [VAL_W-1:0] vout;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_vld_q || m_axis_tready_i;
  assign tail_vld = tok_w[NUM_CELLS].vld;
  assign finish   = (fsm_q == FSM_DONE) && out_free;

  // --------------------------------------------------------------------------
  // Cell row: the token moves one cell per cycle, each cell notes the first
  // matching key and the first free entry it holds.
  // --------------------------------------------------------------------------
  assign tok_w[0] = inj_q;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    logic [CELL_SLOTS-1:0] slot_en;

    for (genvar s = 0; s < CELL_SLOTS; s++) begin : g_slot
      // entries past the pool size are never used
      assign slot_en[s] = ((c * CELL_SLOTS + s) < TABLE_SIZE);
    end

    chme_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CELL_W'(c)),
      .slot_en_i (slot_en),
      .tok_i     (tok_w[c]),
      .tok_o     (tok_w[c+1]),
      .cmt_i     (cmt_q)
    );
  end

  // --------------------------------------------------------------------------
  // Token injection
  // --------------------------------------------------------------------------
  always_comb begin
    inj_d       = '0;
    inj_d.vld   = s_acc;
    inj_d.op    = op_e'(s_axis_tuser_i);
    inj_d.key   = s_axis_tdata_i[KEY_W-1:0];
    inj_d.value = s_axis_tdata_i[IN_DATA_W-1:KEY_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q <= '0;
    end else begin
      inj_q <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_vld) begin
      tail_q <= tok_w[NUM_CELLS];
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: if (s_axis_tvalid_i) fsm_d = FSM_WALK;
      FSM_WALK: if (tail_vld)        fsm_d = FSM_DONE;
      FSM_DONE: if (out_free)        fsm_d = FSM_IDLE;
      default:                       fsm_d = FSM_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: decision on the finished token, store update and result word
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = (fsm_q == FSM_IDLE);

    status    = STS_OK;
    found     = 1'b0;
    vout      = '0;
    count_d   = count_q;
    cmt_d     = '0;
    cmt_d.key = tail_q.key;
    cmt_d.value = tail_q.value;

    case (tail_q.op)
      OP_INSERT: begin
        // full table refuses even a replace
        if (count_q == CNT_W'(TABLE_SIZE)) begin
          status = STS_FULL;
        end else if (tail_q.hit) begin
          cmt_d.en       = 1'b1;
          cmt_d.cell_idx = tail_q.hit_cell;
          cmt_d.slot     = tail_q.hit_slot;
        end else if (tail_q.free) begin
          cmt_d.en       = 1'b1;
          cmt_d.cell_idx = tail_q.free_cell;
          cmt_d.slot     = tail_q.free_slot;
          count_d        = count_q + CNT_W'(1);
        end else begin
          status = STS_FULL;
        end
      end
      OP_REMOVE: begin
        // missing key still reports ok
        if (count_q == '0) begin
          status = STS_EMPTY;
        end else if (tail_q.hit) begin
          cmt_d.en       = 1'b1;
          cmt_d.kill     = 1'b1;
          cmt_d.cell_idx = tail_q.hit_cell;
          cmt_d.slot     = tail_q.hit_slot;
          count_d        = count_q - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (count_q == '0) begin
          status = STS_EMPTY;
        end else if (tail_q.hit) begin
          found = 1'b1;
          vout  = tail_q.hit_value;
        end else begin
          status = STS_MISS;
        end
      end
      OP_NOP:  ;
      default: ;
    endcase

    if (!finish) begin
      cmt_d.en = 1'b0;
      count_d  = count_q;
    end

    m_data_d                      = '0;
    m_data_d[VAL_W-1:0]           = vout;
    m_data_d[VAL_W+CNT_W-1:VAL_W] = count_d;
    m_user_d                      = {found, status};
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q   <= FSM_IDLE;
      count_q <= '0;
      cmt_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      fsm_q   <= fsm_d;
      count_q <= count_d;
      cmt_q   <= cmt_d;
      if (finish) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_count_range, count_q > CNT_W'(TABLE_SIZE))
  `ASSERT_NEVER(a_cmt_vs_inj, cmt_q.en && inj_q.vld)
  `ASSERT_AT(a_tail_in_walk, tail_vld |-> (fsm_q == FSM_WALK))
  `ASSERT_AT(a_count_on_finish, !$stable(count_q) |-> $past(fsm_q == FSM_DONE))

endmodule

// ----- bench/tb_chained_hash_map_engine.sv -----
// ----------------------------------------------------------------------------
// tb_chained_hash_map_engine
// Self-checking bench for the chained hash map engine. A predictor keeps its
// own copy of the bucket chains and entry pool, works out the result of each
// accepted word and a scoreboard compares every returned word field by field.
// Directed words cover the corner cases, then biased random traffic fills the
// map to capacity and drains it again under several idling patterns.
// ----------------------------------------------------------------------------
module tb_chained_hash_map_engine;
  import chme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_ENTRY        = TABLE_SIZE;      // null link
  localparam int ITEMS_PER_PHASE = 460;
  localparam int NUM_PHASES      = 4;
  localparam int POOL_KEYS       = 160;
  localparam int HOT_BUCKETS     = 8;
  localparam int DRAIN_CYCLES    = 4 * (NUM_CELLS + 3);
  localparam int QUIET_LIMIT     = 4000;

  // Expected content of one result word
  typedef struct packed {
    status_e           status;
    logic              found;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  live;
  } outcome_t;

  typedef enum int {FILLING, DRAINING, MIXING} traffic_e;

  // --------------------------------------------------------------------------
  // Scoreboard: map predictor plus queue of outstanding results
  // --------------------------------------------------------------------------
  class map_scoreboard;
    logic [CNT_W-1:0] chain_head [TABLE_SIZE];
    logic [KEY_W-1:0] entry_key  [TABLE_SIZE];
    logic [VAL_W-1:0] entry_val  [TABLE_SIZE];
    logic [CNT_W-1:0] entry_next [TABLE_SIZE];
    logic             entry_used [TABLE_SIZE];
    int unsigned      live;
    int unsigned      peak_live;
    outcome_t         awaited[$];
    int unsigned      mismatches;
    int unsigned      op_tally [4];
    int unsigned      status_tally [4];

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) begin
        chain_head[i] = CNT_W'(NO_ENTRY);
        entry_key[i]  = '0;
        entry_val[i]  = '0;
        entry_next[i] = CNT_W'(NO_ENTRY);
        entry_used[i] = 1'b0;
      end
      live       = 0;
      peak_live  = 0;
      mismatches = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Walk a bucket chain; prev ends on the entry before the match, or on
    // the tail when the key is absent.
    function int lookup_chain(int bucket, logic [KEY_W-1:0] key, output int prev);
      int cur;
      int steps;
      cur   = int'(chain_head[bucket]);
      prev  = NO_ENTRY;
      steps = 0;
      while (cur < TABLE_SIZE && steps < TABLE_SIZE) begin
        if (entry_used[cur] && entry_key[cur] == key) return cur;
        prev = cur;
        cur  = int'(entry_next[cur]);
        steps++;
      end
      return NO_ENTRY;
    endfunction

    function void note_request(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      outcome_t res;
      int       bucket;
      int       hit;
      int       prev;
      int       slot;
      res.status = STS_OK;
      res.found  = 1'b0;
      res.value  = '0;
      bucket     = int'(key % TABLE_SIZE);
      case (op)
        OP_INSERT: begin
          // refused at capacity even if the key is already stored
          if (live >= TABLE_SIZE) begin
            res.status = STS_FULL;
          end else begin
            hit = lookup_chain(bucket, key, prev);
            if (hit != NO_ENTRY) begin
              entry_val[hit] = val;
            end else begin
              slot = NO_ENTRY;
              for (int i = TABLE_SIZE - 1; i >= 0; i--)
                if (!entry_used[i]) slot = i;
              if (slot == NO_ENTRY) begin
                res.status = STS_FULL;
              end else begin
                entry_key[slot]  = key;
                entry_val[slot]  = val;
                entry_next[slot] = CNT_W'(NO_ENTRY);
                entry_used[slot] = 1'b1;
                if (prev != NO_ENTRY) entry_next[prev] = CNT_W'(slot);
                else chain_head[bucket] = CNT_W'(slot);
                live++;
              end
            end
          end
        end
        OP_REMOVE: begin
          if (live == 0) begin
            res.status = STS_EMPTY;
          end else begin
            hit = lookup_chain(bucket, key, prev);
            if (hit != NO_ENTRY) begin
              if (prev != NO_ENTRY) entry_next[prev] = entry_next[hit];
              else chain_head[bucket] = entry_next[hit];
              entry_used[hit] = 1'b0;
              entry_next[hit] = CNT_W'(NO_ENTRY);
              live--;
            end
          end
        end
        OP_GET: begin
          if (live == 0) begin
            res.status = STS_EMPTY;
          end else begin
            hit = lookup_chain(bucket, key, prev);
            if (hit != NO_ENTRY) begin
              res.found = 1'b1;
              res.value = entry_val[hit];
            end else begin
              res.status = STS_MISS;
            end
          end
        end
        default: ;   // unused code: no change
      endcase
      res.live = CNT_W'(live);
      if (live > peak_live) peak_live = live;
      op_tally[op]++;
      status_tally[res.status]++;
      awaited.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [STS_W-1:0] status, logic found, logic [VAL_W-1:0] value,
                      logic [CNT_W-1:0] cnt);
      outcome_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", found, want.found));
        if (value !== want.value)
          report_mismatch($sformatf("value_out %h, want %h", value, want.value));
        if (cnt !== want.live)
          report_mismatch($sformatf("live_entries %0d, want %0d", cnt, want.live));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;   // key [63:0], value_in [127:64]
  logic [OP_W-1:0]       s_axis_tuser_i  = '0;   // op [1:0]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // value_out [63:0], live [70:64], pad
  logic [OUT_USER_W-1:0] m_axis_tuser_o;         // status [1:0], found [2]

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  chained_hash_map_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  map_scoreboard    sb;
  int unsigned      src_idle_pct   = 0;
  int unsigned      sink_stall_pct = 0;
  int unsigned      quiet_cycles   = 0;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];
  traffic_e         traffic = FILLING;
  int unsigned      linger  = 0;

  // --------------------------------------------------------------------------
  // Receiver side: random back-pressure, result check, inactivity counter.
  // Everything samples pre-edge values, so no ordering race with the DUT.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o[STS_W-1:0], m_axis_tuser_o[STS_W],
                      m_axis_tdata_o[VAL_W-1:0], m_axis_tdata_o[VAL_W +: CNT_W]);
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: a hung handshake ends the run
  initial begin
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the word until accepted.
  // tvalid only gets one update per edge, so back-to-back words stay high.
  // --------------------------------------------------------------------------
  task automatic send_word(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {val, key};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, key, val);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keys cluster on a few hot buckets so chains grow long; slots 0 and 1
  // hold the all-zero and all-ones keys.
  task automatic fill_key_pool();
    logic [5:0] hot [HOT_BUCKETS];
    logic [63:0] k;
    foreach (hot[i]) hot[i] = 6'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) begin
      k = rand64();
      if ($urandom_range(99) < 70) k[5:0] = hot[$urandom_range(HOT_BUCKETS - 1)];
      key_pool[i] = k;
    end
  endtask

  // Corner cases: empty map, unused op, chain head/middle/tail, replace,
  // misses on a populated bucket, entry reuse, extreme keys and values.
  task automatic run_directed();
    send_word(OP_GET,    64'd0,   '0);           // get on empty map
    send_word(OP_REMOVE, 64'd0,   '1);           // remove on empty map
    send_word(OP_NOP,    '1,      '1);           // unused code
    send_word(OP_INSERT, 64'd0,   '1);
    send_word(OP_INSERT, 64'd64,  '0);           // same bucket, chain grows
    send_word(OP_INSERT, 64'd128, rand64());
    send_word(OP_INSERT, '1,      64'h5555_5555_5555_5555);
    send_word(OP_GET,    64'd64,  '1);
    send_word(OP_INSERT, 64'd64,  64'hAAAA_AAAA_AAAA_AAAA);  // replace
    send_word(OP_GET,    64'd64,  '0);
    send_word(OP_GET,    64'd192, '0);           // miss within a live chain
    send_word(OP_REMOVE, 64'd192, '0);           // remove of an absent key
    send_word(OP_REMOVE, 64'd0,   '0);           // unlink the chain head
    send_word(OP_GET,    64'd128, '0);
    send_word(OP_REMOVE, 64'd128, '0);           // unlink the tail
    send_word(OP_GET,    64'd0,   '0);
    send_word(OP_INSERT, 64'd0,   64'd1);        // lowest free entry reused
    send_word(OP_GET,    '1,      '0);
    send_word(OP_NOP,    '0,      '0);
    send_word(OP_REMOVE, '1,      '1);
    send_word(OP_REMOVE, 64'd64,  '0);
    send_word(OP_REMOVE, 64'd0,   '0);           // back to empty
    send_word(OP_GET,    '1,      '0);
  endtask

  // Random traffic alternates between filling to capacity (lingering there
  // to hit refused inserts) and draining to empty, with some mixed stretches.
  task automatic run_random(int unsigned n_words);
    op_e              op;
    logic [KEY_W-1:0] key;
    int unsigned      r;
    int unsigned      ins_lim;
    int unsigned      rem_lim;
    for (int unsigned w = 0; w < n_words; w++) begin
      if (linger == 0) begin
        if (traffic == FILLING && sb.live == TABLE_SIZE) linger = $urandom_range(14, 4);
        if (traffic == DRAINING && sb.live == 0) linger = $urandom_range(7, 3);
      end
      if (linger != 0) begin
        linger--;
        if (linger == 0)
          traffic = (traffic == FILLING) ? DRAINING
                  : ($urandom_range(3) == 0 ? MIXING : FILLING);
      end
      if (traffic == MIXING && $urandom_range(59) == 0) traffic = FILLING;
      case (traffic)
        FILLING:  begin ins_lim = 72; rem_lim = 86; end
        DRAINING: begin ins_lim = 16; rem_lim = 80; end
        default:  begin ins_lim = 40; rem_lim = 70; end
      endcase
      r = $urandom_range(99);
      if ($urandom_range(99) < 2) op = OP_NOP;
      else if (r < ins_lim)       op = OP_INSERT;
      else if (r < rem_lim)       op = OP_REMOVE;
      else                        op = OP_GET;
      // a few fully random keys as noise, mostly misses
      key = ($urandom_range(99) < 6) ? rand64() : key_pool[$urandom_range(POOL_KEYS - 1)];
      send_word(op, key, rand64());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned src_pct  [NUM_PHASES];
    int unsigned sink_pct [NUM_PHASES];
    src_pct  = '{0, 87, 0, 20};
    sink_pct = '{0, 0, 87, 20};
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      fill_key_pool();
      run_random(ITEMS_PER_PHASE);
    end
    s_axis_tvalid_i <= 1'b0;

    // let outstanding words return, then watch for strays
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.awaited.size() != 0)
      sb.report_mismatch($sformatf("%0d results never returned", sb.awaited.size()));

    $display("covered %0d words: insert %0d, remove %0d, get %0d, unused op %0d",
             sb.op_tally[OP_INSERT] + sb.op_tally[OP_REMOVE] + sb.op_tally[OP_GET]
             + sb.op_tally[OP_NOP], sb.op_tally[OP_INSERT], sb.op_tally[OP_REMOVE],
             sb.op_tally[OP_GET], sb.op_tally[OP_NOP]);
    $display("outcomes: ok %0d, full %0d, empty %0d, miss %0d; peak occupancy %0d",
             sb.status_tally[STS_OK], sb.status_tally[STS_FULL],
             sb.status_tally[STS_EMPTY], sb.status_tally[STS_MISS], sb.peak_live);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/chme_pkg.sv
design/chme_cell.sv
design/chained_hash_map_engine.sv
bench/tb_chained_hash_map_engine.sv
